### rtl/tcp_session_state_tracker_macros.svh
// Assertion helpers shared by the checker.
`ifndef TCP_SESSION_STATE_TRACKER_MACROS_SVH
`define TCP_SESSION_STATE_TRACKER_MACROS_SVH

// Same-cycle implication.
`define TST_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tst: check failed");

// Next-cycle implication.
`define TST_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tst: check failed");

`endif

### rtl/tst_pkg.sv
package tst_pkg;

  localparam int MODE_W      = 2;
  localparam int IDX_W       = 10;
  localparam int CLASS_W     = 2;
  localparam int STATUS_W    = 3;
  localparam int STATE_W     = 3;
  localparam int PORT_TIME_W = 32;
  localparam int TIMEOUT_W   = 32;
  localparam int CFG_IDX_W   = 2;

  localparam int SESSION_COUNT_DEF = 1024;
  localparam int TIME_WIDTH_DEF    = 32;

  localparam logic [TIMEOUT_W-1:0] TRANS_TIMEOUT_RST = 32'd240000;
  localparam logic [TIMEOUT_W-1:0] EST_TIMEOUT_RST   = 32'd7200000;
  localparam logic [TIMEOUT_W-1:0] SYN_TIMEOUT_RST   = 32'd6000;

  localparam logic [CFG_IDX_W-1:0] CFG_TRANS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYN   = 2'd2;

  localparam logic [CLASS_W-1:0] CLASS_TRANS = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_EST   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_SYN   = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_V6     = 2'd0,
    MODE_V4     = 2'd1,
    MODE_CHECK  = 2'd2,
    MODE_CREATE = 2'd3
  } mode_t;

  typedef enum logic [STATE_W-1:0] {
    TCP_CLOSED   = 3'd0,
    TCP_V6_SYN   = 3'd1,
    TCP_V4_SYN   = 3'd2,
    TCP_FOUR_MIN = 3'd3,
    TCP_ESTAB    = 3'd4,
    TCP_V6_FIN   = 3'd5,
    TCP_V4_FIN   = 3'd6,
    TCP_BOTH_FIN = 3'd7
  } tcp_state_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_UPDATED     = 3'd0,
    STAT_NOT_EXPIRED = 3'd1,
    STAT_RENEWED     = 3'd2,
    STAT_REMOVED     = 3'd3,
    STAT_NOT_VALID   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RENEW_NONE  = 2'd0,
    RENEW_TRANS = 2'd1,
    RENEW_EST   = 2'd2
  } renew_t;

  typedef struct packed {
    tcp_state_t st;
    renew_t     renew;
  } fsm_out_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

  function automatic fsm_out_t tcp_fsm(input tcp_state_t st, input logic side6,
                                       input logic syn, input logic fin,
                                       input logic rst_bit);
    fsm_out_t r;
    r.st    = st;
    r.renew = RENEW_NONE;
    case (st)
      TCP_CLOSED: begin
        if (side6 && syn) begin
          r.st    = TCP_V6_SYN;
          r.renew = RENEW_TRANS;
        end
      end
      TCP_V6_SYN: begin
        if (syn) begin
          if (side6) begin
            r.renew = RENEW_TRANS;
          end else begin
            r.st    = TCP_ESTAB;
            r.renew = RENEW_EST;
          end
        end
      end
      TCP_V4_SYN: begin
        if (side6 && syn) begin
          r.st    = TCP_ESTAB;
          r.renew = RENEW_EST;
        end
      end
      TCP_FOUR_MIN: begin
        if (!rst_bit) begin
          r.st    = TCP_ESTAB;
          r.renew = RENEW_EST;
        end
      end
      TCP_ESTAB: begin
        if (fin) begin
          r.st = side6 ? TCP_V6_FIN : TCP_V4_FIN;
        end else if (rst_bit) begin
          r.st    = TCP_FOUR_MIN;
          r.renew = RENEW_TRANS;
        end else begin
          r.renew = RENEW_EST;
        end
      end
      TCP_V6_FIN, TCP_V4_FIN: begin
        if (fin && ((st == TCP_V6_FIN) != side6)) begin
          r.st    = TCP_BOTH_FIN;
          r.renew = RENEW_TRANS;
        end else begin
          r.renew = RENEW_EST;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/tst_ram.sv
module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tst_ctrl.sv
module tst_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  tst_pkg::dp_status_t    dp_st,
  output tst_pkg::ctrl_cmd_t     cmd,
  output logic                   busy,
  output logic                   done
);

  import tst_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (dp_st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign cmd.clear = (state == S_CLEAR);
  assign cmd.load  = (state == S_IDLE) && start;
  assign cmd.exec  = (state == S_LOOK);
  assign busy      = (state != S_IDLE);

endmodule

### rtl/tst_datapath.sv
module tst_datapath #(
  parameter int SESSION_COUNT = tst_pkg::SESSION_COUNT_DEF,
  parameter int TIME_WIDTH    = tst_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tst_pkg::ctrl_cmd_t              cmd,
  output tst_pkg::dp_status_t             dp_st,
  input  logic [tst_pkg::MODE_W-1:0]      mode,
  input  logic [tst_pkg::IDX_W-1:0]       session_index,
  input  logic                            syn_flag,
  input  logic                            fin_flag,
  input  logic                            rst_flag,
  input  logic [tst_pkg::PORT_TIME_W-1:0] now_ticks,
  input  logic [tst_pkg::CLASS_W-1:0]     expiry_class,
  input  logic                            cfg_write,
  input  logic [tst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tst_pkg::TIMEOUT_W-1:0]   cfg_data,
  output logic [tst_pkg::STATUS_W-1:0]    status,
  output logic [tst_pkg::STATE_W-1:0]     new_state,
  output logic [tst_pkg::PORT_TIME_W-1:0] new_expiry
);

  import tst_pkg::*;

  localparam int ADDR_W = $clog2(SESSION_COUNT);
  localparam int WORD_W = TIME_WIDTH + STATE_W + 1;
  localparam int WIDE_W = TIME_WIDTH + PORT_TIME_W;
  localparam int IDXX_W = IDX_W + ADDR_W;

  logic [TIMEOUT_W-1:0] trans_timeout, est_timeout, syn_timeout;

  logic [ADDR_W-1:0]     clr_cnt;
  logic [ADDR_W-1:0]     item_addr;
  logic                  item_ok;
  mode_t                 item_mode;
  logic                  item_syn, item_fin, item_rstf;
  logic [TIME_WIDTH-1:0] item_now;
  logic [CLASS_W-1:0]    item_class;

  logic [IDXX_W-1:0]     idx_wide;
  logic [ADDR_W-1:0]     in_addr;
  logic [WIDE_W-1:0]     now_wide;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_W-1:0]     ram_rdata;

  logic                  rd_valid;
  tcp_state_t            rd_state;
  logic [TIME_WIDTH-1:0] rd_exp;
  logic [TIME_WIDTH-1:0] exp_diff;
  logic                  expired;
  fsm_out_t              fsm_res;
  logic [TIMEOUT_W-1:0]  ticks;
  logic [WIDE_W-1:0]     ticks_wide;
  logic [TIME_WIDTH-1:0] later;

  logic                  wr_en;
  logic                  wr_valid;
  tcp_state_t            res_state;
  logic [TIME_WIDTH-1:0] res_exp;
  status_t               res_status;
  logic [WIDE_W-1:0]     res_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      trans_timeout <= TRANS_TIMEOUT_RST;
      est_timeout   <= EST_TIMEOUT_RST;
      syn_timeout   <= SYN_TIMEOUT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TRANS: trans_timeout <= cfg_data;
        CFG_EST:   est_timeout   <= cfg_data;
        CFG_SYN:   syn_timeout   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  assign dp_st.clear_last = (clr_cnt == ADDR_W'(SESSION_COUNT - 1));

  assign idx_wide = IDXX_W'(session_index);
  assign in_addr  = idx_wide[ADDR_W-1:0];
  assign now_wide = WIDE_W'(now_ticks);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_addr  <= in_addr;
      item_ok    <= (32'(session_index) < 32'(SESSION_COUNT));
      item_mode  <= mode_t'(mode);
      item_syn   <= syn_flag;
      item_fin   <= fin_flag;
      item_rstf  <= rst_flag;
      item_now   <= now_wide[TIME_WIDTH-1:0];
      item_class <= expiry_class;
    end
  end

  tst_ram #(
    .WIDTH(WORD_W),
    .DEPTH(SESSION_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.load),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  assign rd_exp   = ram_rdata[TIME_WIDTH-1:0];
  assign rd_state = tcp_state_t'(ram_rdata[TIME_WIDTH +: STATE_W]);
  assign rd_valid = ram_rdata[WORD_W-1];

  assign exp_diff = rd_exp - item_now;
  assign expired  = exp_diff[TIME_WIDTH-1];
  assign fsm_res  = tcp_fsm(rd_state, item_mode == MODE_V6, item_syn, item_fin, item_rstf);

  always_comb begin
    ticks = trans_timeout;
    if (item_mode == MODE_CREATE) begin
      if (item_class == CLASS_EST) ticks = est_timeout;
      else if (item_class == CLASS_SYN) ticks = syn_timeout;
    end else if (item_mode != MODE_CHECK && fsm_res.renew == RENEW_EST) begin
      ticks = est_timeout;
    end
  end

  assign ticks_wide = WIDE_W'(ticks);
  assign later      = item_now + ticks_wide[TIME_WIDTH-1:0];

  always_comb begin
    wr_en      = 1'b0;
    wr_valid   = 1'b1;
    res_state  = TCP_CLOSED;
    res_exp    = '0;
    res_status = STAT_NOT_VALID;
    if (item_ok) begin
      if (item_mode == MODE_CREATE) begin
        wr_en      = 1'b1;
        res_exp    = later;
        res_status = STAT_UPDATED;
      end else if (rd_valid) begin
        if (item_mode == MODE_CHECK) begin
          if (!expired) begin
            res_state  = rd_state;
            res_exp    = rd_exp;
            res_status = STAT_NOT_EXPIRED;
          end else if (rd_state == TCP_ESTAB) begin
            wr_en      = 1'b1;
            res_state  = TCP_FOUR_MIN;
            res_exp    = later;
            res_status = STAT_RENEWED;
          end else begin
            wr_en      = 1'b1;
            wr_valid   = 1'b0;
            res_status = STAT_REMOVED;
          end
        end else begin
          wr_en      = 1'b1;
          res_state  = fsm_res.st;
          res_exp    = (fsm_res.renew == RENEW_NONE) ? rd_exp : later;
          res_status = STAT_UPDATED;
        end
      end
    end
  end

  always_comb begin
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.exec && wr_en;
      ram_waddr = item_addr;
      ram_wdata = {wr_valid, res_state, res_exp};
    end
  end

  assign res_wide = WIDE_W'(res_exp);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status     <= res_status;
      new_state  <= res_state;
      new_expiry <= res_wide[PORT_TIME_W-1:0];
    end
  end

endmodule

### rtl/tcp_session_state_tracker.sv
// An accepted item has its session RAM entry read and its inputs registered, is evaluated
// in S_LOOK, and its result is registered onto the outputs with done high.
// Busy holds off a new item until the last is through: the registered read of the session
// RAM is followed by the write-back of the entry. done is high for one cycle only;
// status, new_state and new_expiry hold. Reset: timeouts return to defaults; busy
// stays high while the session RAM is swept clear.
module tcp_session_state_tracker #(
  parameter int SESSION_COUNT = tst_pkg::SESSION_COUNT_DEF,
  parameter int TIME_WIDTH    = tst_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [tst_pkg::MODE_W-1:0]      mode,
  input  logic [tst_pkg::IDX_W-1:0]       session_index,
  input  logic                            syn_flag,
  input  logic                            fin_flag,
  input  logic                            rst_flag,
  input  logic [tst_pkg::PORT_TIME_W-1:0] now_ticks,
  input  logic [tst_pkg::CLASS_W-1:0]     expiry_class,
  output logic                            done,
  output logic [tst_pkg::STATUS_W-1:0]    status,
  output logic [tst_pkg::STATE_W-1:0]     new_state,
  output logic [tst_pkg::PORT_TIME_W-1:0] new_expiry,
  input  logic                            cfg_write,
  input  logic [tst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tst_pkg::TIMEOUT_W-1:0]   cfg_data
);

  import tst_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_st;

  tst_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .dp_st(dp_st),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  tst_datapath #(
    .SESSION_COUNT(SESSION_COUNT),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .dp_st        (dp_st),
    .mode         (mode),
    .session_index(session_index),
    .syn_flag     (syn_flag),
    .fin_flag     (fin_flag),
    .rst_flag     (rst_flag),
    .now_ticks    (now_ticks),
    .expiry_class (expiry_class),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status       (status),
    .new_state    (new_state),
    .new_expiry   (new_expiry)
  );

endmodule

### rtl/tst_checker.sv
`include "tcp_session_state_tracker_macros.svh"

module tst_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic [tst_pkg::STATUS_W-1:0]    status,
  input logic [tst_pkg::STATE_W-1:0]     new_state,
  input logic [tst_pkg::PORT_TIME_W-1:0] new_expiry
);

  import tst_pkg::*;

  `TST_ASSERT_IMP(a_done_when_idle, clk, rst, done, !busy)
  `TST_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  `TST_ASSERT_IMP(a_accept_done, clk, rst, start && !busy, ##2 done)
  `TST_ASSERT_IMP(a_gone_is_zero, clk, rst, done && (status == STAT_REMOVED || status == STAT_NOT_VALID), new_state == TCP_CLOSED && new_expiry == '0)

endmodule

bind tcp_session_state_tracker tst_checker u_tst_checker (.*);

### test/tcp_session_state_tracker_checker.sv
module tcp_session_state_tracker_checker
  import tst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic [MODE_W-1:0]      mode,
  input  logic [IDX_W-1:0]       session_index,
  input  logic                   syn_flag,
  input  logic                   fin_flag,
  input  logic                   rst_flag,
  input  logic [PORT_TIME_W-1:0] now_ticks,
  input  logic [CLASS_W-1:0]     expiry_class,
  input  logic                   done,
  input  logic [STATUS_W-1:0]    status,
  input  logic [STATE_W-1:0]     new_state,
  input  logic [PORT_TIME_W-1:0] new_expiry,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [TIMEOUT_W-1:0]   cfg_data,
  output int                     fail_count,
  output int                     reports_due,
  output int                     reports_checked,
  output logic [4:0]             statuses_seen,
  output logic [7:0]             states_reached
);

  typedef struct {
    status_t                stat;
    tcp_state_t             st;
    logic [PORT_TIME_W-1:0] expiry;
  } session_report_t;

  bit                     live     [SESSION_COUNT_DEF];
  tcp_state_t             phase_of [SESSION_COUNT_DEF];
  logic [PORT_TIME_W-1:0] deadline [SESSION_COUNT_DEF];
  logic [TIMEOUT_W-1:0]   trans_ticks;
  logic [TIMEOUT_W-1:0]   est_ticks;
  logic [TIMEOUT_W-1:0]   syn_ticks;
  session_report_t        reports_q [$];

  initial begin
    fail_count      = 0;
    reports_due     = 0;
    reports_checked = 0;
    statuses_seen   = '0;
    states_reached  = '0;
  end

  function automatic void tcp_transition(input tcp_state_t cur, input bit from_v6,
                                         input bit syn, input bit fin, input bit rs,
                                         output tcp_state_t nxt, output renew_t renew);
    nxt   = cur;
    renew = RENEW_NONE;
    case (cur)
      TCP_CLOSED: begin
        if (from_v6 && syn) begin
          nxt   = TCP_V6_SYN;
          renew = RENEW_TRANS;
        end
      end
      TCP_V6_SYN: begin
        if (syn && from_v6) begin
          renew = RENEW_TRANS;
        end else if (syn) begin
          nxt   = TCP_ESTAB;
          renew = RENEW_EST;
        end
      end
      TCP_V4_SYN: begin
        if (from_v6 && syn) begin
          nxt   = TCP_ESTAB;
          renew = RENEW_EST;
        end
      end
      TCP_FOUR_MIN: begin
        if (!rs) begin
          nxt   = TCP_ESTAB;
          renew = RENEW_EST;
        end
      end
      TCP_ESTAB: begin
        if (fin && from_v6) begin
          nxt = TCP_V6_FIN;
        end else if (fin) begin
          nxt = TCP_V4_FIN;
        end else if (rs) begin
          nxt   = TCP_FOUR_MIN;
          renew = RENEW_TRANS;
        end else begin
          renew = RENEW_EST;
        end
      end
      TCP_V6_FIN, TCP_V4_FIN: begin
        // closing needs a FIN from the side that has not sent one yet
        if (fin && ((cur == TCP_V6_FIN) != from_v6)) begin
          nxt   = TCP_BOTH_FIN;
          renew = RENEW_TRANS;
        end else begin
          renew = RENEW_EST;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic session_report_t apply_item(input mode_t md,
                                                 input logic [IDX_W-1:0] idx,
                                                 input bit syn, input bit fin, input bit rs,
                                                 input logic [PORT_TIME_W-1:0] now,
                                                 input logic [CLASS_W-1:0] cls);
    session_report_t        r;
    tcp_state_t             nxt;
    renew_t                 renew;
    logic [PORT_TIME_W-1:0] margin;
    r.stat   = STAT_NOT_VALID;
    r.st     = TCP_CLOSED;
    r.expiry = '0;
    if (md == MODE_CREATE) begin
      live[idx]     = 1'b1;
      phase_of[idx] = TCP_CLOSED;
      case (cls)
        CLASS_EST: deadline[idx] = now + est_ticks;
        CLASS_SYN: deadline[idx] = now + syn_ticks;
        default:   deadline[idx] = now + trans_ticks;
      endcase
      r.stat   = STAT_UPDATED;
      r.expiry = deadline[idx];
    end else if (live[idx] && md == MODE_CHECK) begin
      margin = deadline[idx] - now;
      if (!margin[PORT_TIME_W-1]) begin
        r.stat   = STAT_NOT_EXPIRED;
        r.st     = phase_of[idx];
        r.expiry = deadline[idx];
      end else if (phase_of[idx] == TCP_ESTAB) begin
        phase_of[idx] = TCP_FOUR_MIN;
        deadline[idx] = now + trans_ticks;
        r.stat   = STAT_RENEWED;
        r.st     = TCP_FOUR_MIN;
        r.expiry = deadline[idx];
      end else begin
        live[idx] = 1'b0;
        r.stat    = STAT_REMOVED;
      end
    end else if (live[idx]) begin
      tcp_transition(phase_of[idx], md == MODE_V6, syn, fin, rs, nxt, renew);
      if (renew == RENEW_TRANS) begin
        deadline[idx] = now + trans_ticks;
      end else if (renew == RENEW_EST) begin
        deadline[idx] = now + est_ticks;
      end
      phase_of[idx] = nxt;
      r.stat   = STAT_UPDATED;
      r.st     = nxt;
      r.expiry = deadline[idx];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    session_report_t want;
    if (rst) begin
      trans_ticks = TRANS_TIMEOUT_RST;
      est_ticks   = EST_TIMEOUT_RST;
      syn_ticks   = SYN_TIMEOUT_RST;
      foreach (live[i]) live[i] = 1'b0;
      reports_q.delete();
    end else begin
      if (done) begin
        if (reports_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result: status %0d state %0d expiry %h",
                     status, new_state, new_expiry);
          end
        end else begin
          want = reports_q.pop_front();
          reports_checked++;
          statuses_seen[want.stat] = 1'b1;
          if (want.stat != STAT_REMOVED && want.stat != STAT_NOT_VALID) begin
            states_reached[want.st] = 1'b1;
          end
          if (status !== want.stat || new_state !== want.st || new_expiry !== want.expiry) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch on result %0d: status exp %0d got %0d, state exp %0d got %0d, expiry exp %h got %h",
                       reports_checked, want.stat, status, want.st, new_state,
                       want.expiry, new_expiry);
            end
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_TRANS: trans_ticks = cfg_data;
          CFG_EST:   est_ticks   = cfg_data;
          CFG_SYN:   syn_ticks   = cfg_data;
          default: begin
          end
        endcase
      end
      if (start && !busy) begin
        reports_q.push_back(apply_item(mode_t'(mode), session_index, syn_flag, fin_flag,
                                       rst_flag, now_ticks, expiry_class));
      end
    end
    reports_due = reports_q.size();
  end

endmodule

### test/tcp_session_state_tracker_tb.sv
module tcp_session_state_tracker_tb;
  import tst_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
  localparam logic [CLASS_W-1:0]   CLASS_SPARE = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [MODE_W-1:0]      mode = '0;
  logic [IDX_W-1:0]       session_index = '0;
  logic                   syn_flag = 1'b0;
  logic                   fin_flag = 1'b0;
  logic                   rst_flag = 1'b0;
  logic [PORT_TIME_W-1:0] now_ticks = '0;
  logic [CLASS_W-1:0]     expiry_class = '0;
  logic                   done;
  logic [STATUS_W-1:0]    status;
  logic [STATE_W-1:0]     new_state;
  logic [PORT_TIME_W-1:0] new_expiry;
  logic                   cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [TIMEOUT_W-1:0]   cfg_data = '0;

  int         fail_count;
  int         reports_due;
  int         reports_checked;
  logic [4:0] statuses_seen;
  logic [7:0] states_reached;

  int items_sent = 0;
  int settings_used = 1;
  int quiet_cycles = 0;
  logic [PORT_TIME_W-1:0] tick_now;
  logic [IDX_W-1:0] hot [6];

  always #10 clk = ~clk;

  tcp_session_state_tracker dut (.*);

  tcp_session_state_tracker_checker chk (.*);

  always @(posedge clk) begin
    if ((start && !busy) || done || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL tcp_session_state_tracker");
      $finish;
    end
  end

  task automatic issue(input mode_t md, input logic [IDX_W-1:0] idx,
                       input logic syn, input logic fin, input logic rs,
                       input logic [PORT_TIME_W-1:0] now, input logic [CLASS_W-1:0] cls);
    @(negedge clk);
    start         <= 1'b1;
    mode          <= md;
    session_index <= idx;
    syn_flag      <= syn;
    fin_flag      <= fin;
    rst_flag      <= rs;
    now_ticks     <= now;
    expiry_class  <= cls;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (reports_due != 0 || busy) @(negedge clk);
  endtask

  task automatic set_timeouts(input logic [TIMEOUT_W-1:0] t, input logic [TIMEOUT_W-1:0] e,
                              input logic [TIMEOUT_W-1:0] s);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_TRANS;
    cfg_data  <= t;
    @(negedge clk);
    cfg_index <= CFG_EST;
    cfg_data  <= e;
    @(negedge clk);
    cfg_index <= CFG_SYN;
    cfg_data  <= s;
    @(negedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= $urandom;
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // mostly coherent traffic on a few hot sessions, some pure noise
  task automatic random_items(input int n, input int idle_pct, input int step_max,
                              input logic [PORT_TIME_W-1:0] first_tick);
    int r;
    mode_t md;
    logic [IDX_W-1:0] idx;
    logic [PORT_TIME_W-1:0] now;
    hot[0] = '0;
    hot[1] = '1;
    for (int i = 2; i < 6; i++) hot[i] = IDX_W'($urandom);
    tick_now = first_tick;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) drain();
      if ($urandom_range(0, 99) < idle_pct) begin
        repeat ($urandom_range(1, 4)) begin
          @(negedge clk);
          start <= 1'b0;
        end
      end
      r = $urandom_range(0, 99);
      if (r < 10) md = MODE_CREATE;
      else if (r < 45) md = MODE_V6;
      else if (r < 80) md = MODE_V4;
      else md = MODE_CHECK;
      if ($urandom_range(0, 99) < 12) begin
        issue(mode_t'($urandom_range(0, 3)), IDX_W'($urandom), 1'($urandom), 1'($urandom),
              1'($urandom), $urandom, CLASS_W'($urandom));
      end else begin
        idx = hot[3'($urandom_range(0, 5))];
        if ($urandom_range(0, 99) < 5) tick_now += step_max * 20;
        else tick_now += $urandom_range(0, step_max);
        now = tick_now;
        issue(md, idx, $urandom_range(0, 99) < 40, $urandom_range(0, 99) < 25,
              $urandom_range(0, 99) < 15, now, CLASS_W'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    logic [PORT_TIME_W-1:0] base;
    base = 32'hFFFF_FF00;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    issue(MODE_CHECK, '0, 1'b1, 1'b1, 1'b1, base, CLASS_TRANS);
    issue(MODE_V6, '1, 1'b1, 1'b0, 1'b0, base, CLASS_TRANS);
    issue(MODE_CREATE, '0, 1'b1, 1'b1, 1'b1, base, CLASS_TRANS);
    issue(MODE_CREATE, '1, 1'b0, 1'b0, 1'b0, base, CLASS_EST);
    issue(MODE_CREATE, 10'd5, 1'b0, 1'b0, 1'b0, base, CLASS_SYN);
    issue(MODE_CREATE, 10'd6, 1'b0, 1'b0, 1'b0, base, CLASS_SPARE);
    issue(MODE_V4, '0, 1'b1, 1'b0, 1'b0, base, CLASS_TRANS);
    issue(MODE_V6, '0, 1'b1, 1'b0, 1'b0, base + 1, CLASS_TRANS);
    issue(MODE_V6, '0, 1'b1, 1'b0, 1'b0, base + 2, CLASS_TRANS);
    issue(MODE_V4, '0, 1'b1, 1'b0, 1'b0, base + 3, CLASS_TRANS);
    issue(MODE_V6, '0, 1'b0, 1'b0, 1'b0, base + 4, CLASS_TRANS);
    issue(MODE_V6, '0, 1'b0, 1'b0, 1'b1, base + 5, CLASS_TRANS);
    issue(MODE_V4, '0, 1'b0, 1'b0, 1'b1, base + 6, CLASS_TRANS);
    issue(MODE_V4, '0, 1'b0, 1'b0, 1'b0, base + 7, CLASS_TRANS);
    issue(MODE_V6, '0, 1'b0, 1'b1, 1'b0, base + 8, CLASS_TRANS);
    issue(MODE_V6, '0, 1'b0, 1'b1, 1'b0, base + 9, CLASS_TRANS);
    issue(MODE_V4, '0, 1'b0, 1'b1, 1'b0, base + 10, CLASS_TRANS);
    issue(MODE_V6, '0, 1'b1, 1'b0, 1'b0, base + 11, CLASS_TRANS);
    issue(MODE_CHECK, '0, 1'b0, 1'b0, 1'b0, base + 11, CLASS_TRANS);
    issue(MODE_CHECK, '0, 1'b0, 1'b0, 1'b0, base + 300000, CLASS_TRANS);
    issue(MODE_V6, '1, 1'b1, 1'b0, 1'b0, base + 20, CLASS_TRANS);
    issue(MODE_V4, '1, 1'b1, 1'b0, 1'b0, base + 21, CLASS_TRANS);
    issue(MODE_CHECK, '1, 1'b1, 1'b1, 1'b1, base + 8000000, CLASS_TRANS);
    issue(MODE_CREATE, 10'd5, 1'b1, 1'b1, 1'b1, base + 30, CLASS_EST);
    issue(MODE_CHECK, 10'd6, 1'b0, 1'b0, 1'b0, base + 240000, CLASS_TRANS);
    issue(MODE_CHECK, 10'd6, 1'b0, 1'b0, 1'b0, base + 240001, CLASS_TRANS);

    drain();
    set_timeouts(32'd300, 32'd1500, 32'd100);
    random_items(120, 0, 300, 32'hFFFF_E000);
    drain();
    set_timeouts('0, '0, '0);
    random_items(110, 47, 40, $urandom);
    drain();
    set_timeouts('1, '1, '1);
    random_items(110, 38, 40, $urandom);
    drain();
    set_timeouts($urandom_range(50, 3000), $urandom_range(50, 3000), $urandom_range(50, 3000));
    random_items(110, 47, 500, $urandom);
    drain();
    set_timeouts($urandom_range(20, 400), $urandom_range(100, 2000), $urandom_range(1, 200));
    random_items(100, 0, 200, 32'h7FFF_F000);

    drain();
    repeat (4) @(negedge clk);
    $display("run covered %0d items under %0d timeout settings, %0d results checked",
             items_sent, settings_used, reports_checked);
    $display("statuses seen %b, session states reached %b", statuses_seen, states_reached);
    if (fail_count == 0 && reports_due == 0) begin
      $display("PASS tcp_session_state_tracker");
    end else begin
      $display("FAIL tcp_session_state_tracker");
    end
    $finish;
  end

endmodule
